[rtl/tli_pkg.sv]
`timescale 1ns / 1ps

package tli_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int DATA_W      = 32;

  // Quotient bits kept by the divider; anything at or above 2**35 saturates
  localparam int QUOT_W      = 35;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/tli_div.sv]
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
// The caller supplies the high part of the dividend as the starting
// remainder (already below the divisor) and the low QUOT_W bits.
module tli_div import tli_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [QUOT_W-1:0]   dividend_lo,
  input  logic [DATA_W-1:0]   rem_init,
  input  logic [DATA_W-1:0]   divisor,
  output div_status_t         status,
  output logic [QUOT_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dsr;
  logic [QUOT_W-1:0] qsh;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   trial;
  logic              take;

  // One trial subtraction per step
  assign trial = {rem, qsh[QUOT_W-1]};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(QUOT_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dsr <= divisor;
      qsh <= dividend_lo;
    end else if (busy) begin
      rem <= take ? DATA_W'(trial - {1'b0, dsr}) : trial[DATA_W-1:0];
      qsh <= {qsh[QUOT_W-2:0], take};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = qsh;

  property p_no_restart;
    @(posedge clk) disable iff (rst) start |-> !busy;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("divider restarted while busy");

endmodule

[rtl/table_linear_interpolator.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | opcode, point_index, x_sample, y_sample,
//         |           |                     | query_value
// out     | output    | out_valid/out_ready | interpolated, out_of_range, zero_segment
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (point_count)
//
// Load: both tables written at the accepting edge.
// Query: end point reads (S_RD0, S_RDN, S_MID), search steps (S_CMPM, then S_CMPL while
// the bracket is wide), fetch, multiply and checks, the one-bit divider, then S_ADD and
// S_DONE; in_ready stays low until then. A zero or saturating segment skips the divider.
// Reset (rst, synchronous) clears control, point_count = 2; tables undefined until loaded.
// A result held in the output register lets one more transaction in; its result waits.
module table_linear_interpolator import tli_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic [ADDR_W-1:0]         point_index,
  input  logic signed [DATA_W-1:0]  x_sample,
  input  logic signed [DATA_W-1:0]  y_sample,
  input  logic signed [DATA_W-1:0]  query_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  interpolated,
  output logic                      out_of_range,
  output logic                      zero_segment,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [COUNT_W-1:0]        cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_RD0    = 14'b00000000000010,
    S_RDN    = 14'b00000000000100,
    S_MID    = 14'b00000000001000,
    S_CMPM   = 14'b00000000010000,
    S_CMPL   = 14'b00000000100000,
    S_FETCH  = 14'b00000001000000,
    S_FETCH2 = 14'b00000010000000,
    S_CALC   = 14'b00000100000000,
    S_MUL    = 14'b00001000000000,
    S_CHK    = 14'b00010000000000,
    S_DIV    = 14'b00100000000000,
    S_ADD    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  localparam logic signed [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int SUM_W = QUOT_W + 2;

  state_t state;
  state_t state_next;

  // Configuration
  logic [COUNT_W-1:0] point_count;
  logic [ADDR_W-1:0]  last_idx;

  // Tables
  logic [DATA_W-1:0]        x_mem [TABLE_DEPTH];
  logic [DATA_W-1:0]        y_mem [TABLE_DEPTH];
  logic                     mem_we;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [DATA_W-1:0] x_rd;
  logic signed [DATA_W-1:0] y_rd;

  // Query state
  logic signed [DATA_W-1:0] val;
  logic [ADDR_W-1:0]        lo;
  logic [ADDR_W-1:0]        hi;
  logic                     oor;
  logic signed [DATA_W-1:0] xi;
  logic signed [DATA_W-1:0] yi;
  logic [DATA_W-1:0]        dvm;
  logic [DATA_W-1:0]        dym;
  logic [DATA_W-1:0]        dxm;
  logic                     neg;
  logic                     zseg;
  logic                     sat;
  logic [2*DATA_W-1:0]      prod;
  logic signed [DATA_W-1:0] res;

  // Search step signals
  logic [ADDR_W:0]   mid_sum;
  logic [ADDR_W-1:0] mid;
  logic              go_right;
  logic [ADDR_W-1:0] lo_step;
  logic [ADDR_W-1:0] hi_step;
  logic              wide;
  logic              next_below;

  // Segment arithmetic
  logic signed [DATA_W:0] dx;
  logic signed [DATA_W:0] dv;
  logic signed [DATA_W:0] dy;
  logic                   ovf;
  logic signed [SUM_W-1:0] sum;

  // Divider
  logic              div_start;
  div_status_t       div_st;
  logic [QUOT_W-1:0] quot;

  logic in_fire;
  logic load_fire;
  logic query_fire;
  logic out_take;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (opcode == OP_LOAD);
  assign query_fire = in_fire && (opcode == OP_QUERY);
  assign cfg_ready  = 1'b1;
  assign out_take   = (state == S_DONE) && (!out_valid || out_ready);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  // Last active index, with the count clamped to 2..TABLE_DEPTH
  always_comb begin
    if (point_count < COUNT_W'(2)) begin
      last_idx = ADDR_W'(1);
    end else if (point_count > COUNT_W'(TABLE_DEPTH)) begin
      last_idx = ADDR_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = ADDR_W'(point_count - 1'b1);
    end
  end

  // Search step
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[ADDR_W:1];
  assign go_right   = val > x_rd;
  assign lo_step    = go_right ? mid : lo;
  assign hi_step    = go_right ? hi : mid;
  assign wide       = (hi_step - lo_step) > ADDR_W'(1);
  assign next_below = x_rd < val;

  // Read address per state
  always_comb begin
    case (state)
      S_RD0:    rd_addr = '0;
      S_RDN:    rd_addr = last_idx;
      S_MID:    rd_addr = mid;
      S_CMPM:   rd_addr = lo_step + 1'b1;
      S_CMPL:   rd_addr = mid;
      S_FETCH:  rd_addr = lo;
      S_FETCH2: rd_addr = lo + 1'b1;
      default:  rd_addr = lo;
    endcase
  end

  // Table memories: one write and one registered read per cycle
  assign mem_we = load_fire && ({1'b0, point_index} < COUNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[point_index] <= x_sample;
      y_mem[point_index] <= y_sample;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      S_IDLE:   if (query_fire) state_next = S_RD0;
      S_RD0:    state_next = S_RDN;
      S_RDN:    state_next = S_MID;
      S_MID:    state_next = S_CMPM;
      S_CMPM:   state_next = wide ? S_CMPL : S_FETCH;
      S_CMPL:   state_next = next_below ? S_CMPM : S_FETCH;
      S_FETCH:  state_next = S_FETCH2;
      S_FETCH2: state_next = S_CALC;
      S_CALC:   state_next = S_MUL;
      S_MUL:    state_next = S_CHK;
      S_CHK: begin
        if (zseg || ovf) begin
          state_next = S_ADD;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV:    if (div_st.done) state_next = S_ADD;
      S_ADD:    state_next = S_DONE;
      S_DONE:   if (out_take) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Segment differences, widened by one bit
  assign dx  = {x_rd[DATA_W-1], x_rd} - {xi[DATA_W-1], xi};
  assign dv  = {val[DATA_W-1], val} - {xi[DATA_W-1], xi};
  assign dy  = {y_rd[DATA_W-1], y_rd} - {yi[DATA_W-1], yi};
  // Quotient would reach 2**35: saturate without dividing
  assign ovf = {3'b000, prod[2*DATA_W-1:QUOT_W]} >= dxm;
  assign sum = SUM_W'(yi) + (neg ? -SUM_W'({2'b00, quot}) : SUM_W'({2'b00, quot}));

  // Query datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          val <= query_value;
          lo  <= '0;
          hi  <= last_idx;
        end
      end
      S_RDN:  oor <= x_rd > val;
      S_MID:  oor <= oor || (x_rd < val);
      S_CMPM: begin
        lo <= lo_step;
        hi <= hi_step;
      end
      S_FETCH2: begin
        xi <= x_rd;
        yi <= y_rd;
      end
      S_CALC: begin
        zseg <= (dx == '0);
        neg  <= dv[DATA_W] ^ dy[DATA_W] ^ dx[DATA_W];
        dvm  <= dv[DATA_W] ? DATA_W'(-dv) : dv[DATA_W-1:0];
        dym  <= dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
        dxm  <= dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
      end
      S_MUL:  prod <= dvm * dym;
      S_CHK:  sat  <= ovf;
      S_ADD: begin
        if (zseg) begin
          res <= yi;
        end else if (sat || (quot > {1'b0, {(QUOT_W-1){1'b0}}} + (QUOT_W'(1) << (QUOT_W-1)))) begin
          res <= neg ? RES_MIN : RES_MAX;
        end else if (sum > SUM_W'(RES_MAX)) begin
          res <= RES_MAX;
        end else if (sum < SUM_W'(RES_MIN)) begin
          res <= RES_MIN;
        end else begin
          res <= sum[DATA_W-1:0];
        end
      end
      default: ;
    endcase
  end

  tli_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_lo (prod[QUOT_W-1:0]),
    .rem_init    ({3'b000, prod[2*DATA_W-1:QUOT_W]}),
    .divisor     (dxm),
    .status      (div_st),
    .quotient    (quot)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      interpolated <= res;
      out_of_range <= oor;
      zero_segment <= zseg;
    end
  end

  // A new result only comes out of the final state
  property p_result_source;
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state == S_DONE);
  endproperty
  a_result_source: assert property (p_result_source)
    else $error("result appeared outside the final state");

  // A load transaction never produces a result
  property p_load_silent;
    @(posedge clk) disable iff (rst) load_fire |=> !$rose(out_valid);
  endproperty
  a_load_silent: assert property (p_load_silent)
    else $error("load transaction produced a result");

  // The search bracket stays ordered and inside the active table
  property p_bracket;
    @(posedge clk) disable iff (rst)
      (state == S_CMPM || state == S_CMPL) |-> (lo < hi) && (hi <= last_idx);
  endproperty
  a_bracket: assert property (p_bracket)
    else $error("search bracket out of order");

  // The divider runs only while the sequencer waits on it
  property p_div_wait;
    @(posedge clk) disable iff (rst) div_st.busy |-> (state == S_DIV);
  endproperty
  a_div_wait: assert property (p_div_wait)
    else $error("divider busy outside the divide state");

endmodule
